>>> rtl/core/rgcl_pkg.sv
// Shared types and constants for the rotated grid cell lookup pipeline.
package rgcl_pkg;

    // North scale: meters per 1e-7 degree of latitude times 2^32
    localparam logic signed [26:0] LAT_SCALE = 27'sd47811575;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CORNER_LAT = 3'd0,
        CFG_CORNER_LNG = 3'd1,
        CFG_LON_SCALE  = 3'd2,
        CFG_COS_ANGLE  = 3'd3,
        CFG_SIN_ANGLE  = 3'd4,
        CFG_CELL_EDGE  = 3'd5,
        CFG_GRID_ROWS  = 3'd6,
        CFG_GRID_COLS  = 3'd7
    } cfg_idx_t;

    // Control that travels beside each word in the divider stages
    typedef struct packed {
        logic valid;
        logic hit;
    } rgcl_tag_t;

endpackage

>>> rtl/core/rotated_grid_cell_lookup.sv
// Top level: rotated grid cell lookup pipeline with configuration registers.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+---------------------------------------
//  fix in   | start, busy               | latitude, longitude
//  result   | done (one-cycle strobe)   | inside_res, row_number, col_number
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One fix enters every cycle; busy stays low and cfg_ready stays high.
// Each fix passes these registers in order (QW = clog2(MAX_DIM+1) quotient bits):
// subtract, scale multiply, partial products, partial sums, Q30 combine,
// range check, one divider stage per quotient bit, output register.
// The receiver cannot stall, so words only advance and are never held.
// rst_n clears all valid bits and loads the register reset values.
module rotated_grid_cell_lookup #(
    parameter int MAX_DIM = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [30:0]  latitude,
    input  logic signed [31:0]  longitude,
    output logic                done,
    output logic                inside_res,
    output logic [12:0]         row_number,
    output logic [12:0]         col_number,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rgcl_pkg::*;

    localparam int QW  = $clog2(MAX_DIM + 1);
    localparam int RW  = 32 + QW;
    localparam int LAT = 7 + QW;

    // ------------------------------------------------------------------
    // Configuration registers
    logic signed [30:0] corner_lat_reg;
    logic signed [31:0] corner_lng_reg;
    logic [31:0]        lon_scale_reg;
    logic signed [31:0] cos_angle_reg;
    logic signed [31:0] sin_angle_reg;
    logic [31:0]        cell_edge_reg;
    logic [12:0]        grid_rows_reg;
    logic [12:0]        grid_cols_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_lat_reg <= '0;
            corner_lng_reg <= '0;
            lon_scale_reg  <= '0;
            cos_angle_reg  <= 32'sh4000_0000;
            sin_angle_reg  <= '0;
            cell_edge_reg  <= 32'h0001_0000;
            grid_rows_reg  <= '0;
            grid_cols_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CORNER_LAT: corner_lat_reg <= $signed(cfg_data[30:0]);
                CFG_CORNER_LNG: corner_lng_reg <= $signed(cfg_data);
                CFG_LON_SCALE:  lon_scale_reg  <= cfg_data;
                CFG_COS_ANGLE:  cos_angle_reg  <= $signed(cfg_data);
                CFG_SIN_ANGLE:  sin_angle_reg  <= $signed(cfg_data);
                CFG_CELL_EDGE:  cell_edge_reg  <= cfg_data;
                CFG_GRID_ROWS:  grid_rows_reg  <= cfg_data[12:0];
                CFG_GRID_COLS:  grid_cols_reg  <= cfg_data[12:0];
            endcase
        end
    end

    // Clamp the counts and hold the grid extent in Q16 meters per axis.
    // A zero count or a zero cell edge gives a zero extent, so every fix misses.
    logic [12:0] rows_clamped;
    logic [12:0] cols_clamped;
    logic [44:0] lim_x_reg;
    logic [44:0] lim_y_reg;

    assign rows_clamped = (int'(grid_rows_reg) > MAX_DIM) ? 13'(MAX_DIM) : grid_rows_reg;
    assign cols_clamped = (int'(grid_cols_reg) > MAX_DIM) ? 13'(MAX_DIM) : grid_cols_reg;

    always_ff @(posedge clk)
    begin
        lim_x_reg <= 45'(cols_clamped) * 45'(cell_edge_reg);
        lim_y_reg <= 45'(rows_clamped) * 45'(cell_edge_reg);
    end

    // ------------------------------------------------------------------
    // Valid bits of the arithmetic stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: subtract the corner
    logic signed [31:0] dlat_reg;
    logic signed [32:0] dlng_reg;

    always_ff @(posedge clk)
    begin
        dlat_reg <= 32'(latitude) - 32'(corner_lat_reg);
        dlng_reg <= 33'(longitude) - 33'(corner_lng_reg);
    end

    // Stage 2: scale both deltas to Q16 meters (floor by dropping 16 bits)
    logic signed [57:0] my_prod_reg;
    logic signed [64:0] mx_prod_reg;
    logic signed [32:0] lon_scale_s;

    assign lon_scale_s = $signed({1'b0, lon_scale_reg});

    always_ff @(posedge clk)
    begin
        my_prod_reg <= 58'(dlat_reg) * 58'(LAT_SCALE);
        mx_prod_reg <= 65'(dlng_reg) * 65'(lon_scale_s);
    end

    // Stage 3: split the metric vector at bit 25 and form partial products
    logic signed [48:0] mx;
    logic signed [41:0] my;
    logic signed [25:0] xl;
    logic signed [23:0] xh;
    logic signed [25:0] yl;
    logic signed [16:0] yh;

    assign mx = mx_prod_reg[64:16];
    assign my = my_prod_reg[57:16];
    assign xl = $signed({1'b0, mx[24:0]});
    assign xh = mx[48:25];
    assign yl = $signed({1'b0, my[24:0]});
    assign yh = my[41:25];

    logic signed [57:0] p_xl_c_reg, p_xl_s_reg, p_yl_c_reg, p_yl_s_reg;
    logic signed [55:0] p_xh_c_reg, p_xh_s_reg;
    logic signed [48:0] p_yh_c_reg, p_yh_s_reg;

    always_ff @(posedge clk)
    begin
        p_xl_c_reg <= 58'(xl) * 58'(cos_angle_reg);
        p_xl_s_reg <= 58'(xl) * 58'(sin_angle_reg);
        p_yl_c_reg <= 58'(yl) * 58'(cos_angle_reg);
        p_yl_s_reg <= 58'(yl) * 58'(sin_angle_reg);
        p_xh_c_reg <= 56'(xh) * 56'(cos_angle_reg);
        p_xh_s_reg <= 56'(xh) * 56'(sin_angle_reg);
        p_yh_c_reg <= 49'(yh) * 49'(cos_angle_reg);
        p_yh_s_reg <= 49'(yh) * 49'(sin_angle_reg);
    end

    // Stage 4: sum the high and low halves of each rotated axis
    logic signed [57:0] hi_x_reg, hi_y_reg;
    logic signed [59:0] lo_x_reg, lo_y_reg;

    always_ff @(posedge clk)
    begin
        hi_x_reg <= 58'(p_xh_c_reg) + 58'(p_yh_s_reg);
        lo_x_reg <= 60'(p_xl_c_reg) + 60'(p_yl_s_reg);
        hi_y_reg <= 58'(p_yh_c_reg) - 58'(p_xh_s_reg);
        lo_y_reg <= 60'(p_yl_c_reg) - 60'(p_xl_s_reg);
    end

    // Stage 5: join the halves and floor-shift out the Q30 fraction
    logic signed [82:0] lx_full;
    logic signed [82:0] ly_full;
    logic signed [52:0] lx_reg;
    logic signed [52:0] ly_reg;

    assign lx_full = (83'(hi_x_reg) <<< 25) + 83'(lo_x_reg);
    assign ly_full = (83'(hi_y_reg) <<< 25) + 83'(lo_y_reg);

    always_ff @(posedge clk)
    begin
        lx_reg <= lx_full[82:30];
        ly_reg <= ly_full[82:30];
    end

    // Stage 6: range check against the grid extent, feed the dividers
    logic          hit_x;
    logic          hit_y;
    rgcl_tag_t     tag6_reg;
    logic [RW-1:0] rem_x_reg;
    logic [RW-1:0] rem_y_reg;

    assign hit_x = !lx_reg[52] && ($unsigned(lx_reg) < 53'(lim_x_reg));
    assign hit_y = !ly_reg[52] && ($unsigned(ly_reg) < 53'(lim_y_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag6_reg <= '0;
        end
        else
        begin
            tag6_reg.valid <= v5_reg;
            tag6_reg.hit   <= v5_reg && hit_x && hit_y;
        end
    end

    // Pass only in-range values; a miss divides zero
    always_ff @(posedge clk)
    begin
        rem_x_reg <= (hit_x && hit_y) ? lx_reg[RW-1:0] : '0;
        rem_y_reg <= (hit_x && hit_y) ? ly_reg[RW-1:0] : '0;
    end

    // Floor-divide each axis by the cell edge
    rgcl_tag_t     tag_x;
    rgcl_tag_t     tag_y;
    logic [QW-1:0] col_q;
    logic [QW-1:0] row_q;

    rgcl_div #(
        .QW (QW),
        .RW (RW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag6_reg),
        .dividend (rem_x_reg),
        .divisor  (cell_edge_reg),
        .tag_out  (tag_x),
        .quotient (col_q)
    );

    rgcl_div #(
        .QW (QW),
        .RW (RW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag6_reg),
        .dividend (rem_y_reg),
        .divisor  (cell_edge_reg),
        .tag_out  (tag_y),
        .quotient (row_q)
    );

    // Output register: one-based cell on a hit, zeros on a miss
    logic        done_reg;
    logic        inside_reg;
    logic [12:0] row_reg;
    logic [12:0] col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            done_reg   <= tag_x.valid;
            inside_reg <= tag_x.valid && tag_x.hit;
            row_reg    <= tag_x.hit ? (13'(row_q) + 13'd1) : 13'd0;
            col_reg    <= tag_x.hit ? (13'(col_q) + 13'd1) : 13'd0;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign row_number = row_reg;
    assign col_number = col_reg;

    // ------------------------------------------------------------------
    // Assertions

    // A result comes only from a fix taken exactly one latency earlier
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted fix");

    // Both axis dividers stay in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        tag_x == tag_y)
        else $error("row and column divider tags differ");

    // A hit names a cell inside the configured grid
    a_hit_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        inside_res |-> (done && row_number != 13'd0 && col_number != 13'd0
                        && row_number <= rows_clamped && col_number <= cols_clamped))
        else $error("hit reports a cell outside the grid");

    // A miss or an idle cycle shows zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_res |-> (row_number == 13'd0 && col_number == 13'd0))
        else $error("nonzero cell reported without a hit");

endmodule

>>> rtl/core/rgcl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module rgcl_div #(
    parameter int QW = 13,
    parameter int RW = 45
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rgcl_pkg::rgcl_tag_t tag_in,
    input  logic [RW-1:0]       dividend,
    input  logic [31:0]         divisor,
    output rgcl_pkg::rgcl_tag_t tag_out,
    output logic [QW-1:0]       quotient
);
    import rgcl_pkg::*;

    rgcl_tag_t       tag_reg  [QW];
    logic [RW-1:0]   rem_reg  [QW];
    logic [QW-1:0]   quot_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        rgcl_tag_t     tag_prev;
        logic [RW-1:0] rem_prev;
        logic [QW-1:0] quot_prev;
        logic [RW-1:0] sub;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] quot_next;

        // Pick the previous stage, or the pipeline input at the first stage
        if (k == 0) begin : g_first
            assign tag_prev  = tag_in;
            assign rem_prev  = dividend;
            assign quot_prev = '0;
        end else begin : g_rest
            assign tag_prev  = tag_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quot_prev = quot_reg[k-1];
        end

        // Try to subtract the shifted divisor and set this quotient bit
        always_comb
        begin
            sub       = RW'(divisor) << BIT;
            take      = (rem_prev >= sub);
            rem_next  = take ? (rem_prev - sub) : rem_prev;
            quot_next = quot_prev;
            quot_next[BIT] = take;
        end

        // Advance control with reset
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_prev;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            quot_reg[k] <= quot_next;
        end
    end

    assign tag_out  = tag_reg[QW-1];
    assign quotient = quot_reg[QW-1];

endmodule
